### rtl/core/conv_pkg.sv
// Shared types, constants and address helpers for the 2D convolution engine.
// No dependencies; every other file of the block imports this package.
package conv_pkg;

    // Store bounds.
    localparam int MAX_IN_CH  = 4;
    localparam int MAX_OUT_CH = 8;
    localparam int MAX_KERNEL = 5;
    localparam int MAX_HEIGHT = 32;
    localparam int MAX_WIDTH  = 32;

    localparam int PIX_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);

    // Field widths of one transaction.
    localparam int OP_W   = 2;
    localparam int OC_W   = 3;
    localparam int IC_W   = 2;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 32;

    // Configuration register widths.
    localparam int KSZ_W = 3;
    localparam int STR_W = 3;
    localparam int PAD_W = 3;
    localparam int NIC_W = 3;
    localparam int NOC_W = 4;
    localparam int DIM_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Upper limits that the registers are saturated to on use.
    localparam int K_HI   = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
    localparam int S_HI   = 4;
    localparam int P_HI   = 4;
    localparam int NIC_HI = (MAX_IN_CH < 4) ? MAX_IN_CH : 4;
    localparam int NOC_HI = (MAX_OUT_CH < 8) ? MAX_OUT_CH : 8;
    localparam int IH_HI  = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;
    localparam int IW_HI  = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

    // Signed window coordinates and the accumulator.
    localparam int COORD_W = 10;
    localparam int ACC_W   = 2 * VAL_W + $clog2(MAX_IN_CH * MAX_KERNEL * MAX_KERNEL) + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_PIXEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_OUTPUT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [OC_W-1:0]         out_channel;
        logic [IC_W-1:0]         in_channel;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    out_of_range;
    } t_out_item;

    // Configuration after saturation into the legal ranges.
    typedef struct packed {
        logic [KSZ_W-1:0] k;
        logic [STR_W-1:0] s;
        logic [PAD_W-1:0] p;
        logic [NIC_W-1:0] nic;
        logic [DIM_W-1:0] ih;
        logic [DIM_W-1:0] iw;
    } t_cfg;

    // Command that starts one output read.
    typedef struct packed {
        logic            oob;
        logic [OC_W-1:0] oc;
        t_coord          y0;
        t_coord          x0;
    } t_seq_cmd;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic idle;
        logic done;
        logic oob;
    } t_seq_stat;

    // Store write and read requests.
    typedef struct packed {
        logic                    pix_we;
        logic                    wgt_we;
        logic [PIX_AW-1:0]       pix_addr;
        logic [WGT_AW-1:0]       wgt_addr;
        logic signed [VAL_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [PIX_AW-1:0] pix_addr;
        logic [WGT_AW-1:0] wgt_addr;
    } t_rd_req;

    // One fetched tap: pixel and weight pair.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] pix;
        logic signed [VAL_W-1:0] wgt;
    } t_tap;

    // Pixel store address: channel, then row, then column.
    function automatic logic [PIX_AW-1:0] pix_addr(
        input logic [IC_W-1:0]  ic,
        input logic [POS_W-1:0] y,
        input logic [POS_W-1:0] x
    );
        logic [PIX_AW-1:0] a;
        a = PIX_AW'(ic) * PIX_AW'(MAX_HEIGHT) + PIX_AW'(y);
        return a * PIX_AW'(MAX_WIDTH) + PIX_AW'(x);
    endfunction

    // Weight store address: filter, channel, kernel row, kernel column.
    function automatic logic [WGT_AW-1:0] wgt_addr(
        input logic [OC_W-1:0]  oc,
        input logic [IC_W-1:0]  ic,
        input logic [KSZ_W-1:0] j,
        input logic [KSZ_W-1:0] t
    );
        logic [WGT_AW-1:0] a;
        a = WGT_AW'(oc) * WGT_AW'(MAX_IN_CH) + WGT_AW'(ic);
        a = a * WGT_AW'(MAX_KERNEL) + WGT_AW'(j);
        return a * WGT_AW'(MAX_KERNEL) + WGT_AW'(t);
    endfunction

endpackage

### rtl/core/conv_in_if.sv
// Input channel: valid/ready handshake carrying one request transaction.
// Depends on conv_pkg for the payload type.
interface conv_in_if;
    import conv_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/conv_out_if.sv
// Output channel: valid/ready handshake carrying one result transaction.
// Depends on conv_pkg for the payload type.
interface conv_out_if;
    import conv_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/conv_store.sv
// Pixel and weight memories, one write and one registered read port each.
// Depends on conv_pkg for request and tap types.
module conv_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  conv_pkg::t_wr_req i_wr,
    input  conv_pkg::t_rd_req i_rd,
    output conv_pkg::t_tap    o_tap
);
    import conv_pkg::*;

    logic signed [VAL_W-1:0] r_pix_mem [PIX_DEPTH];
    logic signed [VAL_W-1:0] r_wgt_mem [WGT_DEPTH];
    logic signed [VAL_W-1:0] r_pix_q;
    logic signed [VAL_W-1:0] r_wgt_q;
    logic                    r_q_vld;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_wr.pix_we) begin
            r_pix_mem[i_wr.pix_addr] <= i_wr.data;
        end
        if (i_wr.wgt_we) begin
            r_wgt_mem[i_wr.wgt_addr] <= i_wr.data;
        end
        r_pix_q <= r_pix_mem[i_rd.pix_addr];
        r_wgt_q <= r_wgt_mem[i_rd.wgt_addr];
    end

    // The read data is a real tap only when the sequencer asked for one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= i_rd.en;
        end
    end

    assign o_tap.vld = r_q_vld;
    assign o_tap.pix = r_pix_q;
    assign o_tap.wgt = r_wgt_q;
endmodule

### rtl/core/conv_mac.sv
// Shared multiply-accumulate unit with final saturation to signed 32 bits.
// Depends on conv_pkg for the tap type and widths.
module conv_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clr,
    input  conv_pkg::t_tap                    i_tap,
    output logic signed [conv_pkg::SUM_W-1:0] o_sum
);
    import conv_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SUM_W){1'b0}}, 1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-SUM_W){1'b1}}, 1'b1, {(SUM_W-1){1'b0}}};

    logic signed [2*VAL_W-1:0] r_prod;
    logic                      r_prod_vld;
    logic signed [ACC_W-1:0]   r_acc;

    // Product stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_tap.vld;
            if (i_clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_prod <= i_tap.pix * i_tap.wgt;
    end

    // Saturate the wide sum into Q16.16.
    always_comb begin
        if (r_acc > SAT_HI) begin
            o_sum = SAT_HI[SUM_W-1:0];
        end else if (r_acc < SAT_LO) begin
            o_sum = SAT_LO[SUM_W-1:0];
        end else begin
            o_sum = r_acc[SUM_W-1:0];
        end
    end
endmodule

### rtl/core/conv_seq.sv
// Tap sequencer: walks input channels and kernel taps of one output read
// and issues store reads for the taps inside the image. Depends on conv_pkg.
module conv_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  conv_pkg::t_seq_cmd  i_cmd,
    input  conv_pkg::t_cfg      i_cfg,
    input  logic                i_slot_free,
    output conv_pkg::t_seq_stat o_stat,
    output conv_pkg::t_rd_req   o_rd,
    output logic                o_clr
);
    import conv_pkg::*;

    // Drain count, loaded on the last tap request and counted to zero.
    localparam logic [1:0] DRAIN_CYC = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [OC_W-1:0]  r_oc;
    t_coord           r_y0;
    t_coord           r_x0;
    logic [IC_W-1:0]  r_c;
    logic [KSZ_W-1:0] r_j;
    logic [KSZ_W-1:0] r_t;
    logic [1:0]       r_drain;
    logic             r_oob;
    logic             r_clr;
    t_rd_req          r_rd;

    t_coord y;
    t_coord x;
    logic   tap_ok;
    logic   last_t;
    logic   last_j;
    logic   last_c;

    // Current tap position and whether it falls inside the image.
    always_comb begin
        y      = r_y0 + t_coord'(r_j);
        x      = r_x0 + t_coord'(r_t);
        tap_ok = (y >= 0) && (y < t_coord'(i_cfg.ih)) &&
                 (x >= 0) && (x < t_coord'(i_cfg.iw));
        last_t = r_t == i_cfg.k - KSZ_W'(1);
        last_j = r_j == i_cfg.k - KSZ_W'(1);
        last_c = NIC_W'(r_c) == i_cfg.nic - NIC_W'(1);
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd.en <= 1'b0;
            r_clr   <= 1'b0;
            r_oob   <= 1'b0;
            r_drain <= '0;
        end else begin
            r_clr   <= 1'b0;
            r_rd.en <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_oc    <= i_cmd.oc;
                        r_y0    <= i_cmd.y0;
                        r_x0    <= i_cmd.x0;
                        r_c     <= '0;
                        r_j     <= '0;
                        r_t     <= '0;
                        r_oob   <= i_cmd.oob;
                        r_clr   <= 1'b1;
                        r_state <= i_cmd.oob ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_rd.en       <= tap_ok;
                    r_rd.pix_addr <= pix_addr(r_c, y[POS_W-1:0], x[POS_W-1:0]);
                    r_rd.wgt_addr <= wgt_addr(r_oc, r_c, r_j, r_t);
                    if (!last_t) begin
                        r_t <= r_t + KSZ_W'(1);
                    end else begin
                        r_t <= '0;
                        if (!last_j) begin
                            r_j <= r_j + KSZ_W'(1);
                        end else begin
                            r_j <= '0;
                            r_c <= r_c + IC_W'(1);
                            if (last_c) begin
                                r_drain <= DRAIN_CYC;
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_drain <= r_drain - 2'd1;
                    end
                end
                S_DONE: begin
                    if (i_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle = r_state == S_IDLE;
    assign o_stat.done = (r_state == S_DONE) && i_slot_free;
    assign o_stat.oob  = r_oob;
    assign o_rd        = r_rd;
    assign o_clr       = r_clr;
endmodule

### rtl/core/conv2d_stride_pad_engine.sv
// Top level of the 2D convolution engine: configuration registers, request
// decode, output register. Depends on conv_pkg, conv_in_if, conv_out_if,
// conv_store, conv_seq and conv_mac.
//
// Weight and pixel writes produce no result and leave the block ready for the
// next request. A read of an output position inside the output size walks
// every kernel tap of every input channel in turn through one
// multiply-accumulate unit, one tap a cycle, and then drains through the
// store read, product and accumulate registers before the result goes to the
// output register. A read outside the output size returns zero with
// out_of_range set. The block takes no request while a read is in progress;
// a finished result waits in the output register without blocking the next
// request. The stores are not cleared at reset: each entry must be written
// before a read uses it.
module conv2d_stride_pad_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    conv_in_if.sink                             i_in,
    conv_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [conv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [conv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import conv_pkg::*;

    logic [KSZ_W-1:0] r_kernel;
    logic [STR_W-1:0] r_stride;
    logic [PAD_W-1:0] r_padding;
    logic [NIC_W-1:0] r_in_ch;
    logic [NOC_W-1:0] r_out_ch;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_width;

    logic      r_out_vld;
    t_out_item r_out;

    t_cfg              cfg;
    logic [NOC_W-1:0]  noc;
    logic [8:0]        row_s;
    logic [8:0]        col_s;
    logic [DIM_W:0]    span_h;
    logic [DIM_W:0]    span_w;
    logic [9:0]        reach_h;
    logic [9:0]        reach_w;
    t_seq_cmd          cmd;
    logic              acc_in;
    logic              start;
    logic              slot_free;
    t_wr_req           wr;
    t_rd_req           rd;
    t_tap              tap;
    t_seq_stat         stat;
    logic              clr;
    logic signed [SUM_W-1:0] mac_sum;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= KSZ_W'(3);
            r_stride  <= STR_W'(1);
            r_padding <= PAD_W'(0);
            r_in_ch   <= NIC_W'(1);
            r_out_ch  <= NOC_W'(1);
            r_height  <= DIM_W'(32);
            r_width   <= DIM_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KERNEL:  r_kernel  <= i_cfg_data[KSZ_W-1:0];
                REG_STRIDE:  r_stride  <= i_cfg_data[STR_W-1:0];
                REG_PADDING: r_padding <= i_cfg_data[PAD_W-1:0];
                REG_IN_CH:   r_in_ch   <= i_cfg_data[NIC_W-1:0];
                REG_OUT_CH:  r_out_ch  <= i_cfg_data[NOC_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[DIM_W-1:0];
                REG_WIDTH:   r_width   <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the registers into their legal ranges.
    always_comb begin
        cfg.k   = (r_kernel == '0) ? KSZ_W'(1) :
                  (r_kernel > KSZ_W'(K_HI)) ? KSZ_W'(K_HI) : r_kernel;
        cfg.s   = (r_stride == '0) ? STR_W'(1) :
                  (r_stride > STR_W'(S_HI)) ? STR_W'(S_HI) : r_stride;
        cfg.p   = (r_padding > PAD_W'(P_HI)) ? PAD_W'(P_HI) : r_padding;
        cfg.nic = (r_in_ch == '0) ? NIC_W'(1) :
                  (r_in_ch > NIC_W'(NIC_HI)) ? NIC_W'(NIC_HI) : r_in_ch;
        cfg.ih  = (r_height == '0) ? DIM_W'(1) :
                  (r_height > DIM_W'(IH_HI)) ? DIM_W'(IH_HI) : r_height;
        cfg.iw  = (r_width == '0) ? DIM_W'(1) :
                  (r_width > DIM_W'(IW_HI)) ? DIM_W'(IW_HI) : r_width;
        noc     = (r_out_ch == '0) ? NOC_W'(1) :
                  (r_out_ch > NOC_W'(NOC_HI)) ? NOC_W'(NOC_HI) : r_out_ch;
    end

    // Output range check: channel below noc, and row*s + k within the
    // padded span, which also covers a window larger than the image.
    always_comb begin
        row_s   = 9'(i_in.data.row) * 9'(cfg.s);
        col_s   = 9'(i_in.data.col) * 9'(cfg.s);
        span_h  = (DIM_W+1)'(cfg.ih) + (DIM_W+1)'({cfg.p, 1'b0});
        span_w  = (DIM_W+1)'(cfg.iw) + (DIM_W+1)'({cfg.p, 1'b0});
        reach_h = 10'(row_s) + 10'(cfg.k);
        reach_w = 10'(col_s) + 10'(cfg.k);
        cmd.oob = (NOC_W'(i_in.data.out_channel) >= noc) ||
                  (reach_h > 10'(span_h)) || (reach_w > 10'(span_w));
        cmd.oc  = i_in.data.out_channel;
        cmd.y0  = t_coord'(row_s) - t_coord'(cfg.p);
        cmd.x0  = t_coord'(col_s) - t_coord'(cfg.p);
    end

    // Request decode: writes go straight to the stores, reads start the walk.
    assign i_in.ready = stat.idle;
    assign acc_in     = i_in.valid && stat.idle;
    assign start      = acc_in && (i_in.data.operation == OP_RD_OUTPUT);

    always_comb begin
        wr.pix_we   = acc_in && (i_in.data.operation == OP_WR_PIXEL) &&
                      (i_in.data.row < POS_W'(MAX_HEIGHT)) &&
                      (i_in.data.col < POS_W'(MAX_WIDTH));
        wr.wgt_we   = acc_in && (i_in.data.operation == OP_WR_WEIGHT) &&
                      (i_in.data.row < POS_W'(MAX_KERNEL)) &&
                      (i_in.data.col < POS_W'(MAX_KERNEL));
        wr.pix_addr = pix_addr(i_in.data.in_channel, i_in.data.row, i_in.data.col);
        wr.wgt_addr = wgt_addr(i_in.data.out_channel, i_in.data.in_channel,
                               i_in.data.row[KSZ_W-1:0], i_in.data.col[KSZ_W-1:0]);
        wr.data     = i_in.data.value;
    end

    conv_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_tap   (tap)
    );

    conv_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_slot_free (slot_free),
        .o_stat      (stat),
        .o_rd        (rd),
        .o_clr       (clr)
    );

    conv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_tap   (tap),
        .o_sum   (mac_sum)
    );

    // Output register: holds one result transaction until it is taken.
    assign slot_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stat.done) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (stat.done) begin
            r_out.sum          <= stat.oob ? '0 : mac_sum;
            r_out.out_of_range <= stat.oob;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
endmodule

### rtl/core/conv_chk.sv
// Port-level checker for the convolution engine and its bind statement.
// Depends on conv_pkg and on the top level conv2d_stride_pad_engine.
module conv_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic [conv_pkg::OP_W-1:0]        i_in_op,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [conv_pkg::SUM_W-1:0] i_out_sum,
    input logic                             i_out_oor
);
    import conv_pkg::*;

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sum) && $stable(i_out_oor))
        else $error("stalled result changed");

    // An out-of-range result always carries a zero sum.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_oor |-> i_out_sum == '0)
        else $error("out-of-range result with nonzero sum");

    // An accepted read leaves the block busy in the following cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_RD_OUTPUT) |=> !i_in_ready)
        else $error("block ready right after a read");

    // Store writes never stall the next request.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_op == OP_WR_WEIGHT || i_in_op == OP_WR_PIXEL) |=> i_in_ready)
        else $error("block busy after a write");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");
endmodule

bind conv2d_stride_pad_engine conv_chk u_conv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sum   (o_out.data.sum),
    .i_out_oor   (o_out.data.out_of_range)
);
